// ----- rtl/fspa_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the fixed slot pool allocator.
// No dependencies; the top level, the divider, the checker and the testbench import this package.
package fspa_pkg;

	// Field widths fixed by the interface.
	localparam int ADDR_W    = 32;
	localparam int ESIZE_W   = 16;
	localparam int COUNT_W   = 9;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 8;
	localparam int CFG_IDX_W = 2;

	// Default built depth of the pool.
	localparam int POOL_SLOTS_DEF = 256;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT    = 2'd2;

	// Configuration reset values.
	localparam logic [ADDR_W-1:0]  POOL_BASE_RST    = 32'd0;
	localparam logic [ESIZE_W-1:0] ELEMENT_SIZE_RST = 16'd1;
	localparam logic [COUNT_W-1:0] MAX_COUNT_RST    = 9'd256;

	// Request kinds.
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd2;

endpackage

// ----- rtl/fixed_slot_pool_allocator.sv -----
`timescale 1ns / 1ps
// Fixed-size slot pool allocator: a LIFO free list kept in a link memory plus a bump counter.
// An allocate request reads the link memory or takes the bump count, with the offset multiply,
// then adds the base to the offset; a free request runs the 32-step radix-2 divider that maps
// the address to a slot; and a request rejected on entry (pool exhausted, address below the
// base, element size zero) is answered from the idle state. A request is taken when start is
// high and busy is low; each request gives one result, shown for a single cycle with done high,
// and it must be captured then as it is not held. Configuration writes are taken whenever
// cfg_we is high, so they must only be issued while busy is low and no result is still due.
// Depends on fspa_pkg, fspa_link_mem and fspa_div.
module fixed_slot_pool_allocator
	import fspa_pkg::*;
#(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic                 mode,
	input  logic [ADDR_W-1:0]    element_address,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [SLOT_W-1:0]    slot_index,
	output logic [ADDR_W-1:0]    slot_address
);

	localparam int IW = $clog2(POOL_SLOTS);
	localparam int CW = $clog2(POOL_SLOTS + 1);
	localparam int PW = IW + ESIZE_W;
	localparam int LW = IW + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;

	logic [1:0]         state_q, state_d;
	logic [ADDR_W-1:0]  pool_base_q;
	logic [ESIZE_W-1:0] element_size_q;
	logic [COUNT_W-1:0] max_count_q;
	logic               head_valid_q, head_valid_d;
	logic [IW-1:0]      head_q, head_d;
	logic [CW-1:0]      bump_q, bump_d;
	logic               done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]  slot_index_q;
	logic [ADDR_W-1:0]  slot_address_q;

	logic               pop_s1;
	logic [IW-1:0]      idx_s1;
	logic [PW-1:0]      prod_s1;

	logic               accept;
	logic               bump_ok;
	logic               free_bad;
	logic [IW-1:0]      alloc_idx;
	logic               load_s1;
	logic               pop_d;
	logic               res_fire;
	logic [STATUS_W-1:0] res_status;
	logic [SLOT_W-1:0]  res_index;
	logic [ADDR_W-1:0]  res_addr;

	logic               div_start;
	logic               div_done;
	logic [ADDR_W-1:0]  div_quot;

	logic               mem_we;
	logic               mem_re;
	logic [LW-1:0]      mem_rdata;

	fspa_link_mem #(
		.DEPTH(POOL_SLOTS),
		.WIDTH(LW)
	) u_link_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(div_quot[IW-1:0]),
		.wdata({head_valid_q, head_q}),
		.re   (mem_re),
		.raddr(head_q),
		.rdata(mem_rdata)
	);

	fspa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(element_address - pool_base_q),
		.divisor (element_size_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		bump_ok  = (32'(bump_q) < 32'(max_count_q)) && (32'(bump_q) < 32'(POOL_SLOTS));
		free_bad = (element_address < pool_base_q) || (element_size_q == '0);

		state_d      = state_q;
		head_valid_d = head_valid_q;
		head_d       = head_q;
		bump_d       = bump_q;
		alloc_idx    = head_q;
		load_s1      = 1'b0;
		pop_d        = 1'b0;
		mem_re       = 1'b0;
		mem_we       = 1'b0;
		div_start    = 1'b0;
		res_fire     = 1'b0;
		res_status   = ST_OK;
		res_index    = '0;
		res_addr     = '0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_ALLOC) begin
						if (head_valid_q) begin
							mem_re  = 1'b1;
							pop_d   = 1'b1;
							load_s1 = 1'b1;
							state_d = ST_ALLOC;
						end else if (bump_ok) begin
							// The bump counter is below the depth here, so its low bits are the slot.
							alloc_idx = bump_q[IW-1:0];
							bump_d    = bump_q + CW'(1);
							load_s1   = 1'b1;
							state_d   = ST_ALLOC;
						end else begin
							res_fire   = 1'b1;
							res_status = ST_EXHAUSTED;
						end
					end else if (free_bad) begin
						res_fire   = 1'b1;
						res_status = ST_BAD_ADDR;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_ALLOC: begin
				res_fire  = 1'b1;
				res_index = SLOT_W'(idx_s1);
				res_addr  = pool_base_q + ADDR_W'(prod_s1);
				if (pop_s1) begin
					head_valid_d = mem_rdata[IW];
					head_d       = mem_rdata[IW-1:0];
				end
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) begin
					res_fire = 1'b1;
					state_d  = ST_IDLE;
					// The bump counter never exceeds the depth, so this also bounds the index.
					if (div_quot >= 32'(bump_q)) begin
						res_status = ST_BAD_ADDR;
					end else begin
						mem_we       = 1'b1;
						head_d       = div_quot[IW-1:0];
						head_valid_d = 1'b1;
						res_index    = SLOT_W'(div_quot[IW-1:0]);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_valid_q   <= 1'b0;
			head_q         <= '0;
			bump_q         <= '0;
			done_q         <= 1'b0;
			pop_s1         <= 1'b0;
			pool_base_q    <= POOL_BASE_RST;
			element_size_q <= ELEMENT_SIZE_RST;
			max_count_q    <= MAX_COUNT_RST;
		end else begin
			state_q      <= state_d;
			head_valid_q <= head_valid_d;
			head_q       <= head_d;
			bump_q       <= bump_d;
			done_q       <= res_fire;
			if (load_s1) begin
				pop_s1 <= pop_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_POOL_BASE:    pool_base_q    <= cfg_data;
					CFG_ELEMENT_SIZE: element_size_q <= cfg_data[ESIZE_W-1:0];
					CFG_MAX_COUNT:    max_count_q    <= cfg_data[COUNT_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// The product is registered before the base is added in the next cycle.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			idx_s1  <= alloc_idx;
			prod_s1 <= PW'(alloc_idx) * PW'(element_size_q);
		end
		if (res_fire) begin
			status_q       <= res_status;
			slot_index_q   <= res_index;
			slot_address_q <= res_addr;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign slot_address = slot_address_q;

endmodule

// ----- rtl/fspa_link_mem.sv -----
`timescale 1ns / 1ps
// Link memory of the free list: one write port, one read port, registered read data.
// Uses widths handed down from the top level only.
module fspa_link_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/fspa_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider that turns a byte offset into a slot index.
// Depends on fspa_pkg for the operand widths; one quotient bit per cycle.
module fspa_div
	import fspa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ADDR_W-1:0]  dividend,
	input  logic [ESIZE_W-1:0] divisor,
	output logic               done,
	output logic [ADDR_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(ADDR_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_W - 1);

	logic               run_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  dvd_q;
	logic [ESIZE_W-1:0] dsr_q;
	logic [ESIZE_W-1:0] rem_q;

	logic [ESIZE_W:0]   shifted;
	logic [ESIZE_W:0]   dsr_ext;
	logic               ge;
	logic [ESIZE_W-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[ADDR_W-1]};
		dsr_ext  = {1'b0, dsr_q};
		ge       = (shifted >= dsr_ext);
		// The remainder always stays below the divisor, so it fits back in ESIZE_W bits.
		rem_next = ge ? ESIZE_W'(shifted - dsr_ext) : shifted[ESIZE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits from the bottom as it shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[ADDR_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- rtl/fspa_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the fixed slot pool allocator, bound to the top level.
// Depends on fspa_pkg for the request kinds and status codes.
module fspa_checker
	import fspa_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                mode,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [SLOT_W-1:0]   slot_index,
	input logic [ADDR_W-1:0]   slot_address
);

	// A result always closes its request, so the block is free again when it is shown.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while the block is still busy");

	// A rejected request reports a zero slot and a zero address.
	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (slot_index == '0 && slot_address == '0))
		else $error("error result carries a nonzero slot or address");

	// Every accepted request either answers at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither answered nor in progress");

	// An allocate that goes on past its first cycle answers in the cycle after.
	a_alloc_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		((start && !busy && mode == MODE_ALLOC) ##1 busy) |=> done)
		else $error("allocate result not delivered after two cycles");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);

// ----- tb/tb_fixed_slot_pool_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fixed slot pool allocator: directed and random requests
// checked against a ledger that tracks the free list, the bump counter and the slots in use.
// Depends on fspa_pkg and fixed_slot_pool_allocator.
import fspa_pkg::*;

typedef struct {
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic [ADDR_W-1:0]   slot_address;
} slot_outcome_t;

class pool_ledger;
	bit [ADDR_W-1:0]  pool_base    = POOL_BASE_RST;
	bit [ESIZE_W-1:0] element_size = ELEMENT_SIZE_RST;
	bit [COUNT_W-1:0] max_count    = MAX_COUNT_RST;

	bit               head_valid;
	bit [SLOT_W-1:0]  head_index;
	bit [COUNT_W-1:0] bump_count;
	bit               link_valid [POOL_SLOTS_DEF];
	bit [SLOT_W-1:0]  link_next  [POOL_SLOTS_DEF];

	// Slots handed out and not yet returned; a free in run_phase that hits a slot hits one of these.
	bit [SLOT_W-1:0]  held_slots [$];
	slot_outcome_t    due_outcomes [$];
	int               mismatches;

	function void write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
		case (idx)
			CFG_POOL_BASE:    pool_base = data;
			CFG_ELEMENT_SIZE: element_size = data[ESIZE_W-1:0];
			CFG_MAX_COUNT:    max_count = data[COUNT_W-1:0];
			default: ;
		endcase
	endfunction

	// Slot that a free of this address would release, or -1 when the address is rejected.
	function int slot_of(bit [ADDR_W-1:0] addr);
		bit [ADDR_W-1:0] idx;
		if (addr < pool_base || element_size == 0)
			return -1;
		idx = (addr - pool_base) / ADDR_W'(element_size);
		if (idx >= ADDR_W'(bump_count) || idx >= POOL_SLOTS_DEF)
			return -1;
		return int'(idx);
	endfunction

	function int held_position(bit [SLOT_W-1:0] slot);
		for (int i = 0; i < held_slots.size(); i++)
			if (held_slots[i] == slot)
				return i;
		return -1;
	endfunction

	// A free that would push a slot already on the free list makes the list cyclic for good.
	function bit hits_unheld_slot(bit [ADDR_W-1:0] addr);
		int slot;
		slot = slot_of(addr);
		return slot >= 0 && held_position(SLOT_W'(slot)) < 0;
	endfunction

	function void note_request(logic m, logic [ADDR_W-1:0] addr);
		slot_outcome_t    o;
		bit [COUNT_W-1:0] limit;
		int               freed;
		int               pos;
		o = '{ST_OK, '0, '0};
		limit = (max_count > COUNT_W'(POOL_SLOTS_DEF)) ? COUNT_W'(POOL_SLOTS_DEF) : max_count;
		if (m == MODE_ALLOC) begin
			if (head_valid) begin
				o.slot_index = head_index;
				head_valid = link_valid[head_index];
				head_index = link_next[o.slot_index];
			end else if (bump_count < limit) begin
				o.slot_index = bump_count[SLOT_W-1:0];
				bump_count++;
			end else begin
				o.status = ST_EXHAUSTED;
			end
			if (o.status == ST_OK) begin
				o.slot_address = pool_base + ADDR_W'(o.slot_index) * ADDR_W'(element_size);
				held_slots.push_back(o.slot_index);
			end
		end else begin
			freed = slot_of(addr);
			if (freed < 0) begin
				o.status = ST_BAD_ADDR;
			end else begin
				link_valid[freed] = head_valid;
				link_next[freed] = head_index;
				head_valid = 1'b1;
				head_index = SLOT_W'(freed);
				o.slot_index = SLOT_W'(freed);
				pos = held_position(SLOT_W'(freed));
				if (pos >= 0)
					held_slots.delete(pos);
			end
		end
		due_outcomes.push_back(o);
	endfunction

	function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] idx,
			logic [ADDR_W-1:0] addr);
		slot_outcome_t o;
		if (due_outcomes.size() == 0) begin
			$error("result with no request outstanding: status %0d slot %0d", st, idx);
			mismatches++;
			return;
		end
		o = due_outcomes.pop_front();
		if (st !== o.status) begin
			$error("status: expected %0d, got %0d", o.status, st);
			mismatches++;
		end
		if (idx !== o.slot_index) begin
			$error("slot_index: expected %0d, got %0d", o.slot_index, idx);
			mismatches++;
		end
		if (addr !== o.slot_address) begin
			$error("slot_address: expected %h, got %h", o.slot_address, addr);
			mismatches++;
		end
	endfunction

	function int outstanding();
		return due_outcomes.size();
	endfunction
endclass

module tb_fixed_slot_pool_allocator;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 1000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;
	logic                 start;
	logic                 busy;
	logic                 mode;
	logic [ADDR_W-1:0]    element_address;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_W-1:0]    slot_index;
	logic [ADDR_W-1:0]    slot_address;

	pool_ledger ledger = new;
	int         quiet_cycles;

	fixed_slot_pool_allocator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element_address(element_address),
		.done(done),
		.status(status),
		.slot_index(slot_index),
		.slot_address(slot_address)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(status, slot_index, slot_address);
			if (start && !busy)
				ledger.note_request(mode, element_address);
			if (cfg_we)
				ledger.write_register(cfg_index, cfg_data);
			if (done || (start && !busy)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Entered and left at a falling edge; returns once the request has been taken.
	task automatic issue(input logic m, input logic [ADDR_W-1:0] addr);
		start = 1'b1;
		mode = m;
		element_address = addr;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (ledger.outstanding() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
	endtask

	// Upper data bits beyond a register's width are junk and must be dropped by the block.
	task automatic program_pool(input bit [ADDR_W-1:0] base, input bit [ESIZE_W-1:0] size,
			input bit [COUNT_W-1:0] limit);
		wait_drained();
		write_reg(CFG_POOL_BASE, base);
		write_reg(CFG_ELEMENT_SIZE, {16'($urandom), size});
		write_reg(CFG_MAX_COUNT, {23'($urandom), limit});
		write_reg(CFG_SPARE, $urandom);
		cfg_we = 1'b0;
	endtask

	task automatic run_phase(input int n_items, input int alloc_pct, input int gap_pct);
		int              pick;
		bit [SLOT_W-1:0] slot;
		bit [ADDR_W-1:0] addr;
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < alloc_pct) begin
				issue(MODE_ALLOC, $urandom);
			end else begin
				if (pick < 92 && ledger.held_slots.size() != 0) begin
					slot = ledger.held_slots[$urandom_range(ledger.held_slots.size() - 1)];
					addr = ledger.pool_base + ADDR_W'(slot) * ADDR_W'(ledger.element_size);
					if (ledger.element_size > 1)
						addr += $urandom_range(ledger.element_size - 1);
				end else begin
					case ($urandom_range(4))
						0: addr = $urandom;
						1: addr = ledger.pool_base - 1;
						2: addr = ledger.pool_base
							+ ADDR_W'(ledger.bump_count) * ADDR_W'(ledger.element_size);
						3: addr = '0;
						default: addr = '1;
					endcase
				end
				if (ledger.hits_unheld_slot(addr))
					addr = (ledger.pool_base != 0) ? ledger.pool_base - 1 : '1;
				issue(MODE_FREE, addr);
			end
			if ($urandom_range(99) == 0)
				wait_drained();
			if ($urandom_range(99) < gap_pct) begin
				start = 1'b0;
				mode = 1'($urandom);
				element_address = $urandom;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	endtask

	initial begin
		bit [SLOT_W-1:0] slot;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		start = 1'b0;
		mode = MODE_ALLOC;
		element_address = '0;
		quiet_cycles = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Three slots of sixteen bytes at 0x1000.
		program_pool(32'h0000_1000, 16'h0010, 9'd3);
		issue(MODE_FREE, 32'h0000_0000);
		issue(MODE_FREE, 32'h0000_1000);
		issue(MODE_ALLOC, 32'hFFFF_FFFF);
		issue(MODE_ALLOC, 32'h0000_0000);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_FREE, 32'h0000_1015);
		issue(MODE_FREE, 32'h0000_1000);
		issue(MODE_FREE, 32'h0000_1030);
		issue(MODE_FREE, 32'hFFFF_FFFF);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_FREE, 32'h0000_102F);
		// Zero stride, and a limit already below the number of slots handed out.
		program_pool(32'hFFFF_FFFF, 16'h0000, 9'd1);
		issue(MODE_FREE, 32'hFFFF_FFFF);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_ALLOC, $urandom);
		// Widest stride near the top of the address space, limit above the built depth.
		program_pool(32'hFFFF_FFF0, 16'hFFFF, 9'd511);
		issue(MODE_ALLOC, $urandom);
		issue(MODE_FREE, 32'hFFFF_FFF0);
		issue(MODE_ALLOC, $urandom);

		program_pool($urandom, 16'($urandom_range(1, 64)), 9'd256);
		run_phase(300, 70, 21);
		program_pool(32'hFFFF_F000, 16'hFFFF, 9'd511);
		run_phase(300, 55, 21);
		program_pool($urandom, 16'($urandom_range(1, 16'hFFFF)), 9'($urandom_range(0, 256)));
		run_phase(300, 50, 51);
		program_pool($urandom, 16'h0000, 9'd0);
		run_phase(150, 50, 51);
		program_pool(32'hFFFF_FFFF, 16'h0001, 9'd256);
		run_phase(300, 40, 0);
		program_pool($urandom, 16'($urandom), 9'($urandom));
		run_phase(300, 50, 0);

		// Returning a slot twice leaves the free list cyclic for good, so it comes last.
		program_pool(32'h0000_0000, 16'h0001, 9'd256);
		issue(MODE_ALLOC, $urandom);
		wait_drained();
		slot = ledger.held_slots[ledger.held_slots.size() - 1];
		issue(MODE_FREE, ADDR_W'(slot));
		issue(MODE_FREE, ADDR_W'(slot));
		repeat (3) issue(MODE_ALLOC, $urandom);

		wait_drained();
		repeat (40) @(negedge clk);
		if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// ----- fixed_slot_pool_allocator.f -----
rtl/fspa_pkg.sv
rtl/fspa_link_mem.sv
rtl/fspa_div.sv
rtl/fixed_slot_pool_allocator.sv
rtl/fspa_checker.sv
tb/tb_fixed_slot_pool_allocator.sv
